[sv/lsq_pkg.sv]
package lsq_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // derived widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WLEN_W = COL_W + 1;
    localparam int HLEN_W = ROW_W + 1;
    localparam int SIDE_W = WLEN_W;
    localparam int CFG_W  = 11;

    // result field widths
    localparam int OUT_X_W    = 10;
    localparam int OUT_Y_W    = 10;
    localparam int OUT_SIDE_W = 11;

    // configuration register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // line buffer request: one write and one read address
    typedef struct packed {
        logic              wr_en;
        logic [COL_W-1:0]  wr_addr;
        logic [SIDE_W-1:0] wr_data;
        logic [COL_W-1:0]  rd_addr;
    } lsq_buf_req_t;

    // frame result from the scan core
    typedef struct packed {
        logic              done;
        logic              found;
        logic [COL_W-1:0]  best_x;
        logic [ROW_W-1:0]  best_y;
        logic [SIDE_W-1:0] best_side;
    } lsq_result_t;

endpackage

[sv/largest_square_raster_scan.sv]
// result beat valid in the cycle after the last cell of a frame is taken
// throughput: one cell per cycle unless a held result stalls input, set by the single line buffer port pair
// a result waiting in the output register stalls input only if it is not taken
// reset: position, neighbours and best square cleared, size registers to 1024
// line buffer is not cleared; entries are used only after the previous row wrote them
module largest_square_raster_scan (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] cell_bit, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] top_left_x, [19:10] top_left_y, [30:20] best_side
    output logic [0:0]  m_tuser,   // [0] found
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_wdata
);

    logic [lsq_pkg::CFG_W-1:0]  grid_width_reg;
    logic [lsq_pkg::CFG_W-1:0]  grid_height_reg;
    logic                       in_fire;
    logic [lsq_pkg::SIDE_W-1:0] up_data;
    lsq_pkg::lsq_buf_req_t      buf_req;
    lsq_pkg::lsq_result_t       result;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_found_reg;
    logic [lsq_pkg::OUT_X_W-1:0]    out_x_reg;
    logic [lsq_pkg::OUT_Y_W-1:0]    out_y_reg;
    logic [lsq_pkg::OUT_SIDE_W-1:0] out_side_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= lsq_pkg::CFG_W'(1024);
            grid_height_reg <= lsq_pkg::CFG_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lsq_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                lsq_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input beat taken while the output register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    lsq_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (buf_req),
        .up_data (up_data)
    );

    lsq_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_fire),
        .cell_bit    (s_tdata[0]),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .up_data     (up_data),
        .buf_req     (buf_req),
        .result      (result)
    );

    // output register
    always_comb
    begin
        if (result.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            out_found_reg <= result.found;
            out_x_reg     <= lsq_pkg::OUT_X_W'(result.best_x);
            out_y_reg     <= lsq_pkg::OUT_Y_W'(result.best_y);
            out_side_reg  <= lsq_pkg::OUT_SIDE_W'(result.best_side);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {1'b0, out_side_reg, out_y_reg, out_x_reg};

    // a held result blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // a new result only follows a taken cell
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_fire))
        else $error("result without a taken cell");

    // found agrees with a non-zero side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[30:20] != 11'd0)))
        else $error("found flag disagrees with side");

    // no result while the frame is still being scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !result.done && !m_tvalid) |=> !m_tvalid)
        else $error("result raised mid-frame");

endmodule

[sv/lsq_line_buf.sv]
module lsq_line_buf (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lsq_pkg::lsq_buf_req_t           req,
    output logic [lsq_pkg::SIDE_W-1:0]      up_data
);

    logic [lsq_pkg::SIDE_W-1:0] row_mem [lsq_pkg::MAX_WIDTH];
    logic [lsq_pkg::SIDE_W-1:0] rd_data_reg;
    logic                       byp_valid_reg;
    logic                       byp_valid_next;
    logic [lsq_pkg::SIDE_W-1:0] byp_data_reg;

    // previous row storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            row_mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg  <= row_mem[req.rd_addr];
        byp_data_reg <= req.wr_data;
    end

    // forward a write that lands on the entry being read
    assign byp_valid_next = req.wr_en && (req.wr_addr == req.rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= byp_valid_next;
        end
    end

    assign up_data = byp_valid_reg ? byp_data_reg : rd_data_reg;

endmodule

[sv/lsq_scan.sv]
module lsq_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          cell_bit,
    input  logic [lsq_pkg::CFG_W-1:0]     grid_width,
    input  logic [lsq_pkg::CFG_W-1:0]     grid_height,
    input  logic [lsq_pkg::SIDE_W-1:0]    up_data,
    output lsq_pkg::lsq_buf_req_t         buf_req,
    output lsq_pkg::lsq_result_t          result
);

    logic [lsq_pkg::COL_W-1:0]  col_reg,       col_next;
    logic [lsq_pkg::ROW_W-1:0]  row_reg,       row_next;
    logic [lsq_pkg::WLEN_W-1:0] prev_len_reg,  prev_len_next;
    logic [lsq_pkg::SIDE_W-1:0] left_reg,      left_next;
    logic [lsq_pkg::SIDE_W-1:0] diag_reg,      diag_next;
    logic [lsq_pkg::SIDE_W-1:0] best_size_reg, best_size_next;
    logic [lsq_pkg::COL_W-1:0]  best_x_reg,    best_x_next;
    logic [lsq_pkg::ROW_W-1:0]  best_y_reg,    best_y_next;

    logic [lsq_pkg::WLEN_W-1:0] w_eff;
    logic [lsq_pkg::HLEN_W-1:0] h_eff;
    logic [lsq_pkg::WLEN_W-1:0] x_plus;
    logic [lsq_pkg::HLEN_W-1:0] y_plus;
    logic [lsq_pkg::SIDE_W-1:0] up;
    logic [lsq_pkg::SIDE_W-1:0] min_ud;
    logic [lsq_pkg::SIDE_W-1:0] min3;
    logic [lsq_pkg::SIDE_W-1:0] val;
    logic [lsq_pkg::WLEN_W-1:0] cand_x;
    logic [lsq_pkg::HLEN_W-1:0] cand_y;
    logic                       better;
    logic                       row_end;
    logic                       frame_end;

    // clamp the frame size registers
    always_comb
    begin
        if (grid_width == '0)
        begin
            w_eff = lsq_pkg::WLEN_W'(1);
        end
        else if (32'(grid_width) > 32'(lsq_pkg::MAX_WIDTH))
        begin
            w_eff = lsq_pkg::WLEN_W'(lsq_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = lsq_pkg::WLEN_W'(grid_width);
        end

        if (grid_height == '0)
        begin
            h_eff = lsq_pkg::HLEN_W'(1);
        end
        else if (32'(grid_height) > 32'(lsq_pkg::MAX_HEIGHT))
        begin
            h_eff = lsq_pkg::HLEN_W'(lsq_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = lsq_pkg::HLEN_W'(grid_height);
        end
    end

    // square side ending at the current cell
    always_comb
    begin
        x_plus = lsq_pkg::WLEN_W'(col_reg) + lsq_pkg::WLEN_W'(1);
        y_plus = lsq_pkg::HLEN_W'(row_reg) + lsq_pkg::HLEN_W'(1);

        // only entries written in the previous row are valid
        if ((row_reg != '0) && (lsq_pkg::WLEN_W'(col_reg) < prev_len_reg))
        begin
            up = up_data;
        end
        else
        begin
            up = '0;
        end

        min_ud = (up < diag_reg) ? up : diag_reg;
        min3   = (min_ud < left_reg) ? min_ud : left_reg;

        if (!cell_bit)
        begin
            val = '0;
        end
        else if ((col_reg == '0) || (row_reg == '0))
        begin
            val = lsq_pkg::SIDE_W'(1);
        end
        else
        begin
            val = min3 + lsq_pkg::SIDE_W'(1);
        end

        better    = val > best_size_reg;
        cand_x    = x_plus - lsq_pkg::WLEN_W'(val);
        cand_y    = y_plus - lsq_pkg::HLEN_W'(val);
        row_end   = x_plus >= w_eff;
        frame_end = row_end && (y_plus >= h_eff);
    end

    // best square so far, first in raster order wins
    always_comb
    begin
        if (better)
        begin
            best_size_next = val;
            best_x_next    = lsq_pkg::COL_W'(cand_x);
            best_y_next    = lsq_pkg::ROW_W'(cand_y);
        end
        else
        begin
            best_size_next = best_size_reg;
            best_x_next    = best_x_reg;
            best_y_next    = best_y_reg;
        end
    end

    // position and neighbour update
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        prev_len_next = prev_len_reg;
        left_next     = left_reg;
        diag_next     = diag_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next      = '0;
                row_next      = '0;
                prev_len_next = '0;
                left_next     = '0;
                diag_next     = '0;
            end
            else if (row_end)
            begin
                col_next      = '0;
                row_next      = lsq_pkg::ROW_W'(y_plus);
                prev_len_next = x_plus;
                left_next     = '0;
                diag_next     = '0;
            end
            else
            begin
                col_next  = lsq_pkg::COL_W'(x_plus);
                left_next = val;
                diag_next = up;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            prev_len_reg  <= '0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            prev_len_reg <= prev_len_next;
            left_reg     <= left_next;
            diag_reg     <= diag_next;
            if (accept)
            begin
                if (frame_end)
                begin
                    best_size_reg <= '0;
                    best_x_reg    <= '0;
                    best_y_reg    <= '0;
                end
                else
                begin
                    best_size_reg <= best_size_next;
                    best_x_reg    <= best_x_next;
                    best_y_reg    <= best_y_next;
                end
            end
        end
    end

    // line buffer: write this cell, prefetch the next column
    always_comb
    begin
        buf_req.wr_en   = accept;
        buf_req.wr_addr = col_reg;
        buf_req.wr_data = val;
        buf_req.rd_addr = col_next;
    end

    // frame result at the last cell
    always_comb
    begin
        result.done      = accept && frame_end;
        result.found     = best_size_next != '0;
        result.best_x    = best_x_next;
        result.best_y    = best_y_next;
        result.best_side = best_size_next;
    end

endmodule
